// ===== hdl/tfg_pkg.sv =====
// ----------------------------------------------------------------------------
// tfg_pkg
// shared types, command codes and constants of the tangent fan generator
// ----------------------------------------------------------------------------
package tfg_pkg;

  localparam int CompBits  = 16;
  localparam int Frac      = CompBits - 2;
  localparam int TrigFrac  = 20;
  localparam int CordicSteps = 16;
  localparam int InBits    = 6 * CompBits;
  localparam int OutBits   = 56;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // configuration register indexes
  localparam logic CFG_COUNT = 1'b0;
  localparam logic CFG_STEP  = 1'b1;

  // datapath command codes
  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_DOT   = 5'd2;
  localparam logic [4:0] OP_DSUM  = 5'd3;
  localparam logic [4:0] OP_PROJ  = 5'd4;
  localparam logic [4:0] OP_TSUB  = 5'd5;
  localparam logic [4:0] OP_NORM  = 5'd6;
  localparam logic [4:0] OP_SQ    = 5'd7;
  localparam logic [4:0] OP_SQI   = 5'd8;
  localparam logic [4:0] OP_SQRT  = 5'd9;
  localparam logic [4:0] OP_DVI   = 5'd10;
  localparam logic [4:0] OP_DIV   = 5'd11;
  localparam logic [4:0] OP_CROSS = 5'd12;
  localparam logic [4:0] OP_WSUM  = 5'd13;
  localparam logic [4:0] OP_CINIT = 5'd14;
  localparam logic [4:0] OP_CSTEP = 5'd15;
  localparam logic [4:0] OP_TRIG  = 5'd16;
  localparam logic [4:0] OP_MUL   = 5'd17;
  localparam logic [4:0] OP_EMIT  = 5'd18;

  typedef struct packed {
    logic [4:0] op;
    logic [4:0] iter;
    logic [3:0] idx;
    logic       last;
    logic       first;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic degen;
    logic out_free;
  } stat_t;

  // arctangent of 2^-i in 1/2^24 turn
  function automatic logic [21:0] atan_lut(input logic [3:0] i);
    logic [21:0] v;
    case (i)
      4'd0:    v = 22'd2097152;
      4'd1:    v = 22'd1238021;
      4'd2:    v = 22'd654136;
      4'd3:    v = 22'd332050;
      4'd4:    v = 22'd166669;
      4'd5:    v = 22'd83416;
      4'd6:    v = 22'd41718;
      4'd7:    v = 22'd20860;
      4'd8:    v = 22'd10430;
      4'd9:    v = 22'd5215;
      4'd10:   v = 22'd2608;
      4'd11:   v = 22'd1304;
      4'd12:   v = 22'd652;
      4'd13:   v = 22'd326;
      4'd14:   v = 22'd163;
      default: v = 22'd81;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tfg_datapath.sv =====
// ----------------------------------------------------------------------------
// tfg_datapath
// projection, normalization, cordic and output register of the fan generator
// ----------------------------------------------------------------------------
module tfg_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tfg_pkg::cmd_t              cmd,
  input  logic [tfg_pkg::InBits-1:0] in_data,
  input  logic [15:0]                angle_step,
  input  logic                       out_tready,
  output tfg_pkg::stat_t             stat,
  output logic                       out_tvalid,
  output logic [tfg_pkg::OutBits-1:0] out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);

  function automatic logic signed [18:0] rnd14(input logic signed [32:0] x);
    logic signed [32:0] t;
    t = x + 33'sd8192;
    return t[32:14];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [24:0] x);
    logic signed [15:0] r;
    if (x > 25'sd32767)       r = 16'sh7fff;
    else if (x < -25'sd32768) r = 16'sh8000;
    else                      r = x[15:0];
    return r;
  endfunction

  logic signed [15:0] n_r [3];
  logic signed [15:0] h_r [3];
  logic signed [31:0] p_r [3];
  logic signed [15:0] d_r;
  logic [30:0]        a_r [3];
  logic [2:0]         tneg_r;
  logic [30:0]        m_r;
  logic               degen_r;
  logic [63:0]        ss_r, sq_rem_r, sq_res_r, sq_bit_r;
  logic [31:0]        dv_rem_r [3];
  logic [14:0]        dv_low_r [3];
  logic [14:0]        dv_q_r   [3];
  logic signed [31:0] cp_r [6];
  logic signed [19:0] w_r [3];
  logic [15:0]        ang_r;
  logic [1:0]         quad_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [25:0] cz_r;
  logic signed [23:0] c_r, s_r;
  logic signed [39:0] mc_r [3];
  logic signed [43:0] ms_r [3];
  logic               ovalid_r;
  logic [3:0]         oidx_r;
  logic signed [15:0] odir_r [3];
  logic               olast_r, odeg_r;

  logic signed [15:0] v [3];
  logic [31:0]        root;
  logic [30:0]        asel;
  logic [63:0]        sq_try;
  logic signed [18:0] rnd [3];
  logic signed [18:0] tv  [3];
  logic [17:0]        tabs [3];
  logic [30:0]        mx;
  logic signed [20:0] dsum;
  logic signed [33:0] cdx, cdy;
  logic signed [25:0] catan;
  logic signed [33:0] xr, yr;
  logic signed [23:0] cr, sr;
  logic signed [44:0] osum [3];
  logic signed [24:0] osh  [3];
  logic [45:0]        num  [3];
  logic [32:0]        dtry [3];

  assign root = sq_res_r[31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i]    = tneg_r[i] ? -$signed({1'b0, dv_q_r[i]}) : $signed({1'b0, dv_q_r[i]});
      rnd[i]  = rnd14(33'(p_r[i]));
      tv[i]   = 19'(h_r[i]) - rnd[i];
      tabs[i] = tv[i][18] ? 18'(-tv[i]) : 18'(tv[i]);
      num[i]  = 46'({a_r[i], 14'd0}) + 46'(root >> 1);
      dtry[i] = {dv_rem_r[i], dv_low_r[i][14]};
      osum[i] = 45'(mc_r[i]) + 45'(ms_r[i]) + 45'sd524288;
      osh[i]  = osum[i][44:20];
    end
    dsum = 21'(rnd[0]) + 21'(rnd[1]) + 21'(rnd[2]);
    mx = 31'(tabs[0]);
    if (31'(tabs[1]) > mx) mx = 31'(tabs[1]);
    if (31'(tabs[2]) > mx) mx = 31'(tabs[2]);
    case (cmd.iter[1:0])
      2'd0:    asel = a_r[0];
      2'd1:    asel = a_r[1];
      default: asel = a_r[2];
    endcase
    sq_try = sq_res_r + sq_bit_r;
    cdx   = cy_r >>> cmd.iter[3:0];
    cdy   = cx_r >>> cmd.iter[3:0];
    catan = $signed({4'b0, tfg_pkg::atan_lut(cmd.iter[3:0])});
    xr = cx_r + 34'sd512;
    yr = cy_r + 34'sd512;
    cr = xr[33:10];
    sr = yr[33:10];
  end

  assign stat.norm_done = m_r[30];
  assign stat.degen     = degen_r;
  assign stat.out_free  = !ovalid_r || out_tready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      tfg_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          n_r[i] <= in_data[16*i +: 16];
          h_r[i] <= in_data[48 + 16*i +: 16];
        end
        ang_r <= '0;
      end
      tfg_pkg::OP_DOT: for (int i = 0; i < 3; i++) p_r[i] <= n_r[i] * h_r[i];
      tfg_pkg::OP_DSUM: begin
        if (dsum > 21'sd32767)       d_r <= 16'sh7fff;
        else if (dsum < -21'sd32768) d_r <= 16'sh8000;
        else                         d_r <= dsum[15:0];
      end
      tfg_pkg::OP_PROJ: for (int i = 0; i < 3; i++) p_r[i] <= d_r * n_r[i];
      tfg_pkg::OP_TSUB: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i]    <= 31'(tabs[i]);
          tneg_r[i] <= tv[i][18];
        end
        m_r     <= mx;
        degen_r <= (mx == '0);
        ss_r    <= '0;
      end
      tfg_pkg::OP_NORM: begin
        if (m_r < 31'h0040_0000) begin
          m_r <= m_r << 8;
          for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] << 8;
        end else begin
          m_r <= m_r << 1;
          for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] << 1;
        end
      end
      tfg_pkg::OP_SQ: ss_r <= ss_r + 64'(asel) * 64'(asel);
      tfg_pkg::OP_SQI: begin
        sq_rem_r <= ss_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      tfg_pkg::OP_SQRT: begin
        if (sq_rem_r >= sq_try) begin
          sq_rem_r <= sq_rem_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      tfg_pkg::OP_DVI: begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[i] <= 32'(num[i][45:15]);
          dv_low_r[i] <= num[i][14:0];
          dv_q_r[i]   <= '0;
        end
      end
      tfg_pkg::OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (dtry[i] >= {1'b0, root}) begin
            dv_rem_r[i] <= 32'(dtry[i] - {1'b0, root});
            dv_q_r[i]   <= {dv_q_r[i][13:0], 1'b1};
          end else begin
            dv_rem_r[i] <= dtry[i][31:0];
            dv_q_r[i]   <= {dv_q_r[i][13:0], 1'b0};
          end
          dv_low_r[i] <= {dv_low_r[i][13:0], 1'b0};
        end
      end
      tfg_pkg::OP_CROSS: begin
        cp_r[0] <= n_r[1] * v[2];
        cp_r[1] <= n_r[2] * v[1];
        cp_r[2] <= n_r[2] * v[0];
        cp_r[3] <= n_r[0] * v[2];
        cp_r[4] <= n_r[0] * v[1];
        cp_r[5] <= n_r[1] * v[0];
      end
      tfg_pkg::OP_WSUM:
        for (int i = 0; i < 3; i++)
          w_r[i] <= 20'(rnd14(33'(cp_r[2*i]) - 33'(cp_r[2*i+1])));
      tfg_pkg::OP_CINIT: begin
        quad_r <= ang_r[15:14];
        cx_r   <= tfg_pkg::CORDIC_GAIN;
        cy_r   <= '0;
        cz_r   <= $signed({4'b0, ang_r[13:0], 8'b0});
      end
      tfg_pkg::OP_CSTEP: begin
        if (!cz_r[25]) begin
          cx_r <= cx_r - cdx;
          cy_r <= cy_r + cdy;
          cz_r <= cz_r - catan;
        end else begin
          cx_r <= cx_r + cdx;
          cy_r <= cy_r - cdy;
          cz_r <= cz_r + catan;
        end
      end
      tfg_pkg::OP_TRIG: begin
        case (quad_r)
          2'd0:    begin c_r <= cr;  s_r <= sr;  end
          2'd1:    begin c_r <= -sr; s_r <= cr;  end
          2'd2:    begin c_r <= -cr; s_r <= -sr; end
          default: begin c_r <= sr;  s_r <= -cr; end
        endcase
      end
      tfg_pkg::OP_MUL: begin
        for (int i = 0; i < 3; i++) begin
          mc_r[i] <= c_r * v[i];
          ms_r[i] <= s_r * w_r[i];
        end
      end
      tfg_pkg::OP_EMIT: begin
        oidx_r  <= cmd.idx;
        olast_r <= cmd.last;
        odeg_r  <= degen_r;
        for (int i = 0; i < 3; i++) begin
          if (degen_r)        odir_r[i] <= '0;
          else if (cmd.first) odir_r[i] <= v[i];
          else                odir_r[i] <= sat16(osh[i]);
        end
        ang_r <= ang_r + angle_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.op == tfg_pkg::OP_EMIT) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0, odir_r[2], odir_r[1], odir_r[0], oidx_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = odeg_r;

endmodule

// ===== hdl/tfg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfg_ctrl
// sequencer that steps the datapath through one request and its fan
// ----------------------------------------------------------------------------
module tfg_ctrl #(
  parameter int MAX_DIRECTIONS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [4:0]     direction_count,
  input  tfg_pkg::stat_t stat,
  output tfg_pkg::cmd_t  cmd
);

  localparam int KW = $clog2(MAX_DIRECTIONS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DOT   = 5'd1;
  localparam logic [4:0] S_DSUM  = 5'd2;
  localparam logic [4:0] S_PROJ  = 5'd3;
  localparam logic [4:0] S_TSUB  = 5'd4;
  localparam logic [4:0] S_NORM  = 5'd5;
  localparam logic [4:0] S_SQ    = 5'd6;
  localparam logic [4:0] S_SQI   = 5'd7;
  localparam logic [4:0] S_SQRT  = 5'd8;
  localparam logic [4:0] S_DVI   = 5'd9;
  localparam logic [4:0] S_DIV   = 5'd10;
  localparam logic [4:0] S_CROSS = 5'd11;
  localparam logic [4:0] S_WSUM  = 5'd12;
  localparam logic [4:0] S_DIR   = 5'd13;
  localparam logic [4:0] S_CSTEP = 5'd14;
  localparam logic [4:0] S_TRIG  = 5'd15;
  localparam logic [4:0] S_MUL   = 5'd16;
  localparam logic [4:0] S_EMIT  = 5'd17;

  logic [4:0]    state_r, state_nxt;
  logic [4:0]    it_r, it_nxt;
  logic [KW-1:0] k_r, k_nxt, cnt_r, cnt_nxt, cap;
  logic [KW+3:0] kx;
  logic          last;

  assign in_tready = (state_r == S_IDLE);
  assign kx   = (KW+4)'(k_r);
  assign last = ((KW+1)'(k_r) + (KW+1)'(1)) == (KW+1)'(cnt_r);

  always_comb begin
    if (int'(direction_count) > MAX_DIRECTIONS) cap = KW'(MAX_DIRECTIONS);
    else                                        cap = KW'(direction_count);
  end

  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = tfg_pkg::OP_NOP;
    cmd.iter  = it_r;
    cmd.idx   = kx[3:0];
    cmd.last  = last;
    cmd.first = (k_r == '0);
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        cmd.op  = tfg_pkg::OP_LOAD;
        cnt_nxt = cap;
        k_nxt   = '0;
        if (cap != '0) state_nxt = S_DOT;
      end
      S_DOT:  begin cmd.op = tfg_pkg::OP_DOT;  state_nxt = S_DSUM; end
      S_DSUM: begin cmd.op = tfg_pkg::OP_DSUM; state_nxt = S_PROJ; end
      S_PROJ: begin cmd.op = tfg_pkg::OP_PROJ; state_nxt = S_TSUB; end
      S_TSUB: begin cmd.op = tfg_pkg::OP_TSUB; state_nxt = S_NORM; end
      S_NORM: begin
        if (stat.degen) begin
          state_nxt = S_DIR;
        end else if (stat.norm_done) begin
          it_nxt    = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.op = tfg_pkg::OP_NORM;
        end
      end
      S_SQ: begin
        cmd.op = tfg_pkg::OP_SQ;
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd2) state_nxt = S_SQI;
      end
      S_SQI: begin cmd.op = tfg_pkg::OP_SQI; it_nxt = '0; state_nxt = S_SQRT; end
      S_SQRT: begin
        cmd.op = tfg_pkg::OP_SQRT;
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd31) state_nxt = S_DVI;
      end
      S_DVI: begin cmd.op = tfg_pkg::OP_DVI; it_nxt = '0; state_nxt = S_DIV; end
      S_DIV: begin
        cmd.op = tfg_pkg::OP_DIV;
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd14) state_nxt = S_CROSS;
      end
      S_CROSS: begin cmd.op = tfg_pkg::OP_CROSS; state_nxt = S_WSUM; end
      S_WSUM:  begin cmd.op = tfg_pkg::OP_WSUM;  state_nxt = S_DIR;  end
      S_DIR: begin
        if (stat.degen || k_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = tfg_pkg::OP_CINIT;
          it_nxt    = '0;
          state_nxt = S_CSTEP;
        end
      end
      S_CSTEP: begin
        cmd.op = tfg_pkg::OP_CSTEP;
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd15) state_nxt = S_TRIG;
      end
      S_TRIG: begin cmd.op = tfg_pkg::OP_TRIG; state_nxt = S_MUL;  end
      S_MUL:  begin cmd.op = tfg_pkg::OP_MUL;  state_nxt = S_EMIT; end
      S_EMIT: if (stat.out_free) begin
        cmd.op = tfg_pkg::OP_EMIT;
        k_nxt  = k_r + KW'(1);
        state_nxt = last ? S_IDLE : S_DIR;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      it_r    <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/tangent_fan_generator.sv =====
// order: from a request to the first direction the 32-step sqrt and 15-step divide dominate,
//   normalize shifts vary; a degenerate hint goes from normalize straight to emit
// each rotated direction: 16-step cordic plus cinit, trig, mul and emit; degenerate ones: emit only
// throughput: one request at a time; next request taken once its last direction is out
// a zero count request is taken and gives nothing
// reset: synchronous active low; count returns to 4, step to 16384, fsm to idle
// ----------------------------------------------------------------------------
// tangent_fan_generator
// builds a fan of unit tangents around a contact normal from a hint vector
// ----------------------------------------------------------------------------
module tangent_fan_generator #(
  parameter int MAX_DIRECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // normal_x, normal_y, normal_z, hint_x, hint_y, hint_z
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // direction_index, dir_x, dir_y, dir_z, zero pad
  output logic [55:0] out_tdata,
  output logic        out_tuser, // degenerate
  output logic        out_tlast, // last_direction
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // configuration registers; the user must write them only between requests, the block does not enforce it
  logic [4:0]  dcount_r;
  logic [15:0] astep_r;

  tfg_pkg::cmd_t  cmd;
  tfg_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcount_r <= 5'd4;
      astep_r  <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_addr)
        tfg_pkg::CFG_COUNT: dcount_r <= cfg_wdata[4:0];
        default:            astep_r  <= cfg_wdata;
      endcase
    end
  end

  // sequencer: walks dot, projection, normalize, sqrt, divide, then the fan
  tfg_ctrl #(
    .MAX_DIRECTIONS(MAX_DIRECTIONS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .direction_count (dcount_r),
    .stat            (stat),
    .cmd             (cmd)
  );

  // arithmetic and output register; output register decouples the two sides
  tfg_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_tdata),
    .angle_step (astep_r),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/tfg_checker.sv =====
// ----------------------------------------------------------------------------
// tfg_checker
// port level checks of the tangent fan generator
// ----------------------------------------------------------------------------
module tfg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // degenerate results carry zero vectors
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[51:4] == 48'd0)
    else $error("degenerate result with nonzero vector");

  // while a direction that is not the last one is shown the input stays closed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request accepted mid run");

  // after the last direction of a run the next direction restarts at zero
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || out_tdata[3:0] == 4'd0
      || $stable(out_tdata))
    else $error("run did not restart at index zero");

endmodule

bind tangent_fan_generator tfg_checker u_tfg_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives unit normals and hint vectors into the tangent fan generator and
// checks every emitted direction against a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------

// scoreboard: predicts the fan of each taken request and checks the directions
class fan_scoreboard;
  typedef struct {
    logic [3:0]         idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
    logic               degen;
  } fan_dir_t;

  fan_dir_t    pending_dirs[$];
  int unsigned fan_count = 4;
  int unsigned step_turn = 16384;
  int          mismatches = 0;

  // arctangent of 2^-i in 1/2^24 turn
  longint atan_turn[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                            20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function longint round_sh(longint x, int sh);
    return (x + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function longint clamp_comp(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function bit [63:0] int_sqrt(bit [63:0] s);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 16-step cordic on the residual angle, quadrant applied afterwards
  function void turn_sincos(int unsigned ang, output longint c, output longint s);
    int unsigned q;
    longint zr, xr, yr, dx, dy, cr, sr;
    q = (ang >> 14) & 3;
    zr = longint'(ang & 16'h3FFF) <<< 8;
    xr = 64'sd652032874;
    yr = 0;
    for (int i = 0; i < 16; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (zr >= 0) begin
        xr -= dx; yr += dy; zr -= atan_turn[i];
      end else begin
        xr += dx; yr -= dy; zr += atan_turn[i];
      end
    end
    cr = round_sh(xr, 10);
    sr = round_sh(yr, 10);
    case (q)
      0: begin c = cr;  s = sr;  end
      1: begin c = -sr; s = cr;  end
      2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endfunction

  function void set_register(bit addr, int unsigned val);
    if (addr == tfg_pkg::CFG_COUNT) fan_count = val & 5'h1F;
    else step_turn = val & 16'hFFFF;
  endfunction

  // works out the whole fan of one taken request
  function void note_request(logic [95:0] req);
    longint n[3], h[3], t[3], v[3], w[3], dot, c, s, mag;
    bit [63:0] a[3], m, ss, r;
    bit degen;
    int unsigned cnt;
    fan_dir_t fd;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = longint'($signed(req[16*i +: 16]));
      h[i] = longint'($signed(req[48 + 16*i +: 16]));
    end
    for (int i = 0; i < 3; i++) dot += round_sh(n[i] * h[i], 14);
    dot = clamp_comp(dot);
    for (int i = 0; i < 3; i++) begin
      t[i] = h[i] - round_sh(dot * n[i], 14);
      a[i] = t[i] < 0 ? 64'(-t[i]) : 64'(t[i]);
    end
    m = a[0] > a[1] ? a[0] : a[1];
    if (a[2] > m) m = a[2];
    degen = (m == 0);
    if (!degen) begin
      // bring the largest magnitude into [2^30, 2^31)
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
      end
      while (m >= (64'd1 << 31)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
      end
      ss = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      r = int_sqrt(ss);
      for (int i = 0; i < 3; i++) begin
        mag = longint'(((a[i] << 14) + (r >> 1)) / r);
        v[i] = t[i] < 0 ? -mag : mag;
      end
      w[0] = round_sh(n[1] * v[2] - n[2] * v[1], 14);
      w[1] = round_sh(n[2] * v[0] - n[0] * v[2], 14);
      w[2] = round_sh(n[0] * v[1] - n[1] * v[0], 14);
    end else begin
      for (int i = 0; i < 3; i++) begin v[i] = 0; w[i] = 0; end
    end
    cnt = fan_count > 16 ? 16 : fan_count;
    for (int unsigned k = 0; k < cnt; k++) begin
      fd.idx = k[3:0];
      fd.last = (k + 1 == cnt);
      fd.degen = degen;
      if (degen) begin
        fd.x = 0; fd.y = 0; fd.z = 0;
      end else if (k == 0) begin
        fd.x = v[0][15:0]; fd.y = v[1][15:0]; fd.z = v[2][15:0];
      end else begin
        turn_sincos((k * step_turn) & 16'hFFFF, c, s);
        fd.x = 16'(clamp_comp(round_sh(c * v[0] + s * w[0], 20)));
        fd.y = 16'(clamp_comp(round_sh(c * v[1] + s * w[1], 20)));
        fd.z = 16'(clamp_comp(round_sh(c * v[2] + s * w[2], 20)));
      end
      pending_dirs.push_back(fd);
    end
  endfunction

  function void check_direction(logic [55:0] data, logic user, logic lst);
    fan_dir_t e;
    if (pending_dirs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected direction: data %h", data);
      return;
    end
    e = pending_dirs.pop_front();
    if (data[3:0] !== e.idx || data[19:4] !== e.x || data[35:20] !== e.y ||
        data[51:36] !== e.z || lst !== e.last || user !== e.degen) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"direction mismatch: exp idx %0d (%0d,%0d,%0d) last %b degen %b,",
                  " got idx %0d (%0d,%0d,%0d) last %b degen %b"},
                 e.idx, e.x, e.y, e.z, e.last, e.degen, data[3:0], $signed(data[19:4]),
                 $signed(data[35:20]), $signed(data[51:36]), lst, user);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 500; // covers a full fan of sixteen directions

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [95:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  bit          calm = 1'b0; // no idling on either side while set
  int          cycles = 0;
  fan_scoreboard fans = new();

  tangent_fan_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side stalls about 36 percent of the time unless calm
  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 36);

  // every taken direction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) fans.check_direction(out_tdata, out_tuser, out_tlast);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one request: optional gap, then hold until taken; returns on a falling edge
  task automatic send_request(logic [95:0] req);
    if (!calm && $urandom_range(99) < 36) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = req;
    do @(posedge clk); while (!in_tready);
    fans.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_vec(int nx, int ny, int nz, int hx, int hy, int hz);
    send_request({hz[15:0], hy[15:0], hx[15:0], nz[15:0], ny[15:0], nx[15:0]});
  endtask

  // wait for the fan to drain, then let any zero-count request finish
  task automatic drain;
    in_tvalid = 1'b0;
    while (fans.pending_dirs.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_register(logic addr, int unsigned val);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = val[15:0];
    fans.set_register(addr, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly random vectors, some axis normals, some parallel or zero hints
  function automatic logic [95:0] random_request();
    int pick, ax;
    logic [15:0] nv [3];
    logic [15:0] hv [3];
    pick = $urandom_range(99);
    if (pick < 60) return {$urandom(), $urandom(), $urandom()};
    ax = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      nv[i] = '0;
      hv[i] = 16'($urandom());
    end
    nv[ax] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    if (pick >= 85) begin
      // hint along the normal or zero: degenerate fan
      for (int i = 0; i < 3; i++) if (i != ax) hv[i] = '0;
      if ($urandom_range(3) == 0) hv[ax] = '0;
    end
    return {hv[2], hv[1], hv[0], nv[2], nv[1], nv[0]};
  endfunction

  int unsigned phase_count[7] = '{4, 0, 1, 16, 31, 7, 0};
  int unsigned phase_step[7]  = '{16384, 12345, 0, 4096, 65535, 9362, 0};

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed requests under the reset settings
    send_vec(16384, 0, 0, 0, 16384, 0);
    send_vec(0, 16384, 0, 16384, 16384, 0);
    send_vec(0, 0, 16384, 0, 0, 5000);            // hint parallel to normal
    send_vec(16384, 0, 0, 0, 0, 0);               // zero hint
    send_vec(0, -16384, 0, 0, -9000, 0);          // hint parallel to normal, both along -y
    send_vec(-32768, -32768, -32768, -32768, -32768, -32768);
    send_vec(32767, 32767, 32767, 32767, 32767, 32767);
    send_vec(32767, -32768, 0, -32768, 32767, 1);
    send_vec(0, 0, 0, 123, -456, 789);            // non-unit normal
    send_vec(11585, 11585, 0, 0, 0, 16384);
    send_vec(9459, 9459, 9459, 16384, 0, 0);
    send_vec(16384, 0, 0, 1, 0, 0);               // hint cancels exactly
    send_vec(16384, 0, 0, 0, 1, 0);               // tiny tangent
    send_vec(0, 16384, 0, -32768, 0, 32767);
    send_vec(-16384, 0, 0, 0, 0, -32768);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_register(tfg_pkg::CFG_COUNT, p == 6 ? $urandom_range(17) : phase_count[p]);
      write_register(tfg_pkg::CFG_STEP, p == 6 ? $urandom_range(65535) : phase_step[p]);
      calm = (p == 3);
      for (int i = 0; i < 63; i++) send_request(random_request());
      drain();
      calm = 1'b0;
    end

    if (fans.mismatches == 0 && fans.pending_dirs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
